>>> hw/rtl/prewitt_edge_magnitude_macros.svh
// Assertion macros shared by the edge magnitude RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef PREWITT_EDGE_MAGNITUDE_MACROS_SVH
`define PREWITT_EDGE_MAGNITUDE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PEM_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PEM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/pem_pkg.sv
// Shared types and constants of the Prewitt edge magnitude block.
// Depends on nothing; imported by every module of the block.
`timescale 1ns / 1ps

package pem_pkg;

    localparam int PIX_W      = 8;
    localparam int SQ_W       = 20;
    localparam int ROOT_STEPS = 8;
    localparam int RAD_W      = 2 * ROOT_STEPS;
    localparam int SUM_W      = SQ_W + 1;
    localparam logic [PIX_W-1:0] MAG_MAX = 8'd255;

    localparam logic REG_LINE_WIDTH   = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             frame_start;
    } pem_in_t;

    typedef struct packed {
        logic [PIX_W-1:0] magnitude;
        logic             frame_last;
    } pem_out_t;

    typedef struct packed {
        logic             valid;
        logic             emit;
        logic             last;
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] bot;
    } pem_win_t;

    typedef struct packed {
        logic            valid;
        logic            last;
        logic [SQ_W-1:0] sqx;
        logic [SQ_W-1:0] sqy;
    } pem_sq_t;

endpackage

>>> hw/rtl/pem_line_store.sv
// Raster position tracking and the two line store memories with forwarding.
// Depends on pem_pkg and prewitt_edge_magnitude_macros.svh.
`timescale 1ns / 1ps
`include "prewitt_edge_magnitude_macros.svh"

module pem_line_store #(
    parameter int MAX_LINE_WIDTH = 256
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  pem_pkg::pem_in_t  in_data,
    input  logic              adv,
    input  logic [8:0]        line_width,
    input  logic [12:0]       frame_height,
    output pem_pkg::pem_win_t win
);
    import pem_pkg::*;

    localparam int CW = $clog2(MAX_LINE_WIDTH);
    localparam int WW = (CW + 1 > 9) ? CW + 1 : 9;
    localparam logic [WW-1:0] W_MIN = WW'(3);
    localparam logic [WW-1:0] W_MAX = WW'(MAX_LINE_WIDTH);
    localparam logic [12:0] H_MIN = 13'd3;
    localparam logic [12:0] H_MAX = 13'd4096;

    logic [PIX_W-1:0] upper_mem  [MAX_LINE_WIDTH];
    logic [PIX_W-1:0] middle_mem [MAX_LINE_WIDTH];

    logic [CW-1:0]    col_reg, col_next;
    logic [11:0]      row_reg, row_next;
    logic             b_valid_reg;
    logic             fwd_reg;
    logic [CW-1:0]    b_col_reg;
    logic [PIX_W-1:0] b_pix_reg;
    logic             b_emit_reg;
    logic             b_last_reg;
    logic [PIX_W-1:0] fwd_top_reg;
    logic [PIX_W-1:0] fwd_mid_reg;
    logic [PIX_W-1:0] rd_upper_reg;
    logic [PIX_W-1:0] rd_middle_reg;

    logic             acc;
    logic [WW-1:0]    lw_ext;
    logic [WW-1:0]    w_eff;
    logic [WW-1:0]    w_m1;
    logic [12:0]      h_eff;
    logic [12:0]      h_m1;
    logic [CW-1:0]    col_cur;
    logic [11:0]      row_cur;
    logic             col_end;
    logic             row_end;
    logic [PIX_W-1:0] cur_top;
    logic [PIX_W-1:0] cur_mid;

    assign acc = in_valid && adv;

    always_comb
    begin
        lw_ext = WW'(line_width);
        if (lw_ext < W_MIN)
        begin
            w_eff = W_MIN;
        end
        else if (lw_ext > W_MAX)
        begin
            w_eff = W_MAX;
        end
        else
        begin
            w_eff = lw_ext;
        end
        w_m1 = w_eff - WW'(1);

        if (frame_height < H_MIN)
        begin
            h_eff = H_MIN;
        end
        else if (frame_height > H_MAX)
        begin
            h_eff = H_MAX;
        end
        else
        begin
            h_eff = frame_height;
        end
        h_m1 = h_eff - 13'd1;

        col_cur = in_data.frame_start ? '0 : col_reg;
        row_cur = in_data.frame_start ? '0 : row_reg;
        col_end = WW'(col_cur) >= w_m1;
        row_end = {1'b0, row_cur} >= h_m1;

        if (col_end)
        begin
            col_next = '0;
            row_next = row_end ? '0 : row_cur + 12'd1;
        end
        else
        begin
            col_next = col_cur + CW'(1);
            row_next = row_cur;
        end

        cur_top = fwd_reg ? fwd_top_reg : rd_upper_reg;
        cur_mid = fwd_reg ? fwd_mid_reg : rd_middle_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            row_reg     <= '0;
            b_valid_reg <= 1'b0;
            fwd_reg     <= 1'b0;
        end
        else if (adv)
        begin
            b_valid_reg <= in_valid;
            if (acc)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
                fwd_reg <= b_valid_reg && (b_col_reg == col_cur);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            b_col_reg     <= col_cur;
            b_pix_reg     <= in_data.pixel;
            b_emit_reg    <= (row_cur >= 12'd2) && (col_cur >= CW'(2));
            b_last_reg    <= row_end && col_end;
            fwd_top_reg   <= cur_mid;
            fwd_mid_reg   <= b_pix_reg;
            rd_upper_reg  <= upper_mem[col_cur];
            rd_middle_reg <= middle_mem[col_cur];
        end
        if (adv && b_valid_reg)
        begin
            upper_mem[b_col_reg]  <= cur_mid;
            middle_mem[b_col_reg] <= b_pix_reg;
        end
    end

    assign win.valid = b_valid_reg && adv;
    assign win.emit  = b_emit_reg;
    assign win.last  = b_last_reg;
    assign win.top   = cur_top;
    assign win.mid   = cur_mid;
    assign win.bot   = b_pix_reg;

    `PEM_ASSERT_NEXT(a_accept_fills_stage, clk, rst_n, acc, b_valid_reg, "accepted word lost")
    `PEM_ASSERT_NEXT(a_stall_holds_stage, clk, rst_n, !adv && b_valid_reg, b_valid_reg && $stable(b_col_reg), "stage changed under stall")
    `PEM_ASSERT_SAME(a_forward_same_entry, clk, rst_n, fwd_reg && b_valid_reg, b_col_reg == $past(b_col_reg), "forward on a different entry")

endmodule

>>> hw/rtl/pem_gradient.sv
// Column window, Prewitt gradients and their squares, two register stages.
// Depends on pem_pkg.
`timescale 1ns / 1ps

module pem_gradient (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  pem_pkg::pem_win_t win,
    output pem_pkg::pem_sq_t  sq
);
    import pem_pkg::*;

    logic [PIX_W-1:0]   col_reg [6];
    logic               g_valid_reg;
    logic               g_last_reg;
    logic signed [10:0] gx_reg;
    logic signed [10:0] gy_reg;
    logic               s_valid_reg;
    logic               s_last_reg;
    logic [SQ_W-1:0]    sqx_reg;
    logic [SQ_W-1:0]    sqy_reg;

    logic [9:0]         left_sum;
    logic [9:0]         right_sum;
    logic [9:0]         up_sum;
    logic [9:0]         down_sum;
    logic signed [10:0] gx_next;
    logic signed [10:0] gy_next;
    logic [9:0]         ax;
    logic [9:0]         ay;

    always_comb
    begin
        left_sum  = 10'(col_reg[0]) + 10'(col_reg[1]) + 10'(col_reg[2]);
        right_sum = 10'(win.top) + 10'(win.mid) + 10'(win.bot);
        up_sum    = 10'(col_reg[0]) + 10'(col_reg[3]) + 10'(win.top);
        down_sum  = 10'(col_reg[2]) + 10'(col_reg[5]) + 10'(win.bot);
        gx_next   = $signed({1'b0, right_sum}) - $signed({1'b0, left_sum});
        gy_next   = $signed({1'b0, up_sum}) - $signed({1'b0, down_sum});
        ax        = gx_reg[10] ? 10'(-gx_reg) : gx_reg[9:0];
        ay        = gy_reg[10] ? 10'(-gy_reg) : gy_reg[9:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
            begin
                col_reg[i] <= '0;
            end
            g_valid_reg <= 1'b0;
            s_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            g_valid_reg <= win.valid && win.emit;
            s_valid_reg <= g_valid_reg;
            if (win.valid)
            begin
                col_reg[0] <= col_reg[3];
                col_reg[1] <= col_reg[4];
                col_reg[2] <= col_reg[5];
                col_reg[3] <= win.top;
                col_reg[4] <= win.mid;
                col_reg[5] <= win.bot;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            gx_reg     <= gx_next;
            gy_reg     <= gy_next;
            g_last_reg <= win.last;
            sqx_reg    <= {10'b0, ax} * {10'b0, ax};
            sqy_reg    <= {10'b0, ay} * {10'b0, ay};
            s_last_reg <= g_last_reg;
        end
    end

    assign sq.valid = s_valid_reg;
    assign sq.last  = s_last_reg;
    assign sq.sqx   = sqx_reg;
    assign sq.sqy   = sqy_reg;

endmodule

>>> hw/rtl/pem_root.sv
// Pipelined integer square root, one result bit per stage, saturated to 255.
// Depends on pem_pkg.
`timescale 1ns / 1ps

module pem_root (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  pem_pkg::pem_sq_t  sq,
    output logic              out_valid,
    output pem_pkg::pem_out_t out_data
);
    import pem_pkg::*;

    logic [SUM_W-1:0] energy;
    logic             v_reg    [ROOT_STEPS+1];
    logic             last_reg [ROOT_STEPS+1];
    logic             sat_reg  [ROOT_STEPS+1];
    logic [RAD_W-1:0] rad_reg  [ROOT_STEPS+1];
    logic [PIX_W-1:0] res_reg  [ROOT_STEPS+1];
    logic [PIX_W-1:0] res_next [ROOT_STEPS];

    always_comb
    begin
        logic [PIX_W-1:0] trial;
        logic [RAD_W-1:0] trial_sq;
        energy = SUM_W'(sq.sqx) + SUM_W'(sq.sqy);
        for (int k = 0; k < ROOT_STEPS; k++)
        begin
            trial       = res_reg[k] | (PIX_W'(1) << (ROOT_STEPS - 1 - k));
            trial_sq    = RAD_W'(trial) * RAD_W'(trial);
            res_next[k] = (trial_sq <= rad_reg[k]) ? trial : res_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= ROOT_STEPS; k++)
            begin
                v_reg[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            v_reg[0] <= sq.valid;
            for (int k = 0; k < ROOT_STEPS; k++)
            begin
                v_reg[k+1] <= v_reg[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            last_reg[0] <= sq.last;
            sat_reg[0]  <= energy[SUM_W-1:RAD_W] != '0;
            rad_reg[0]  <= energy[RAD_W-1:0];
            res_reg[0]  <= '0;
            for (int k = 0; k < ROOT_STEPS; k++)
            begin
                last_reg[k+1] <= last_reg[k];
                sat_reg[k+1]  <= sat_reg[k];
                rad_reg[k+1]  <= rad_reg[k];
                res_reg[k+1]  <= res_next[k];
            end
        end
    end

    assign out_valid           = v_reg[ROOT_STEPS];
    assign out_data.magnitude  = sat_reg[ROOT_STEPS] ? MAG_MAX : res_reg[ROOT_STEPS];
    assign out_data.frame_last = last_reg[ROOT_STEPS];

endmodule

>>> hw/rtl/prewitt_edge_magnitude.sv
// The twelve stages are the line store read, gradients, squares, energy and eight root bits.
// Throughput: one pixel word per cycle while out_stall stays low.
// The pipeline moves as a whole; a stalled result holds every stage.
// Reset clears the raster position, the window and all valid flags, and sets
// line_width and frame_height to 200; the line store memories are not cleared.
`timescale 1ns / 1ps

module prewitt_edge_magnitude #(
    parameter int MAX_LINE_WIDTH = 256
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  pem_pkg::pem_in_t  in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output pem_pkg::pem_out_t out_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import pem_pkg::*;

    logic [8:0]  line_width_reg;
    logic [12:0] frame_height_reg;
    logic        adv;
    logic        cfg_write;
    pem_win_t    win;
    pem_sq_t     sq;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign adv       = !(out_valid && out_stall);
    assign in_stall  = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg   <= 9'd200;
            frame_height_reg <= 13'd200;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                REG_LINE_WIDTH:   line_width_reg   <= pwdata[8:0];
                REG_FRAME_HEIGHT: frame_height_reg <= pwdata[12:0];
                default:          line_width_reg   <= line_width_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_LINE_WIDTH:   prdata = 32'(line_width_reg);
            REG_FRAME_HEIGHT: prdata = 32'(frame_height_reg);
            default:          prdata = '0;
        endcase
    end

    pem_line_store #(
        .MAX_LINE_WIDTH(MAX_LINE_WIDTH)
    ) u_line_store (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_data      (in_data),
        .adv          (adv),
        .line_width   (line_width_reg),
        .frame_height (frame_height_reg),
        .win          (win)
    );

    pem_gradient u_gradient (
        .clk   (clk),
        .rst_n (rst_n),
        .adv   (adv),
        .win   (win),
        .sq    (sq)
    );

    pem_root u_root (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .sq        (sq),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

endmodule

>>> tb/tb.sv
// Self-checking testbench for the Prewitt edge magnitude block.
// It streams raster frames of pixel words through the block under several line and
// frame sizes, predicts every edge result itself and compares them; it depends on pem_pkg.
`timescale 1ns / 1ps

module tb;

    import pem_pkg::*;

    localparam int LINE_DEPTH = 256;
    localparam int MAX_ROWS = 4096;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT = 500000;
    localparam int HOLD_CYCLES = 200;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    pem_in_t     in_data = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    pem_out_t    out_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    pem_in_t  pixel_words[$];
    pem_out_t expected_edges[$];

    logic [8:0]  cfg_width;
    logic [12:0] cfg_height;
    logic [7:0]  upper_line [LINE_DEPTH];
    logic [7:0]  middle_line [LINE_DEPTH];
    logic [7:0]  window_cols [6];
    int          col_pos;
    int          row_pos;

    int errors;
    int words_accepted;
    int results_seen;
    int settings_used;
    int cycles;
    int feed_gap;
    bit feed_calm;
    int stall_left;
    int hold_left;
    bit hold_done;
    bit drain_calm;

    prewitt_edge_magnitude DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        forever
        begin
            #10 clk = ~clk;
        end
    end

    function automatic int eff_width();
        if (cfg_width < 3) return 3;
        if (cfg_width > LINE_DEPTH) return LINE_DEPTH;
        return int'(cfg_width);
    endfunction

    function automatic int eff_height();
        if (cfg_height < 3) return 3;
        if (cfg_height > MAX_ROWS) return MAX_ROWS;
        return int'(cfg_height);
    endfunction

    function automatic logic [7:0] root_of(input int energy);
        int root;
        int trial;
        root = 0;
        if (energy >= 65536) return 8'd255;
        for (int b = 7; b >= 0; b--)
        begin
            trial = root | (1 << b);
            if (trial * trial <= energy) root = trial;
        end
        return 8'(root);
    endfunction

    function automatic int pick_pause();
        int k;
        k = $urandom_range(0, 9);
        if (k < 7) return $urandom_range(1, 3);
        if (k < 9) return $urandom_range(4, 8);
        return $urandom_range(15, 40);
    endfunction

    function automatic logic [7:0] random_pixel();
        int k;
        k = $urandom_range(0, 7);
        if (k == 0) return 8'd0;
        if (k == 1) return 8'd255;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic predict_edge(input pem_in_t word);
        int w;
        int h;
        int c;
        int r;
        int top;
        int mid;
        int bot;
        int gx;
        int gy;
        pem_out_t res;
        w = eff_width();
        h = eff_height();
        if (word.frame_start)
        begin
            col_pos = 0;
            row_pos = 0;
        end
        c = col_pos;
        r = row_pos;
        if (c >= LINE_DEPTH) c = LINE_DEPTH - 1;
        top = upper_line[c];
        mid = middle_line[c];
        bot = word.pixel;
        upper_line[c] = 8'(mid);
        middle_line[c] = 8'(bot);
        if (r >= 2 && c >= 2)
        begin
            gx = (top + mid + bot) - (window_cols[0] + window_cols[1] + window_cols[2]);
            gy = (window_cols[0] + window_cols[3] + top) - (window_cols[2] + window_cols[5] + bot);
            res.magnitude = root_of(gx * gx + gy * gy);
            res.frame_last = (r >= h - 1 && c >= w - 1);
            expected_edges.push_back(res);
        end
        window_cols[0] = window_cols[3];
        window_cols[1] = window_cols[4];
        window_cols[2] = window_cols[5];
        window_cols[3] = 8'(top);
        window_cols[4] = 8'(mid);
        window_cols[5] = 8'(bot);
        if (c >= w - 1)
        begin
            col_pos = 0;
            row_pos = (r >= h - 1) ? 0 : r + 1;
        end
        else
        begin
            col_pos = c + 1;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data <= '0;
            feed_gap = 0;
            feed_calm = 1'b0;
        end
        else
        begin
            bit busy;
            busy = in_valid;
            if (in_valid && !in_stall)
            begin
                predict_edge(in_data);
                words_accepted++;
                busy = 1'b0;
            end
            if (!busy)
            begin
                if (feed_gap > 0)
                begin
                    feed_gap--;
                    in_valid <= 1'b0;
                end
                else if (pixel_words.size() > 0)
                begin
                    in_data <= pixel_words.pop_front();
                    in_valid <= 1'b1;
                    if ($urandom_range(0, 63) == 0) feed_calm = !feed_calm;
                    if (!feed_calm && $urandom_range(0, 3) == 0) feed_gap = pick_pause();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
            hold_left = 0;
            hold_done = 1'b0;
            drain_calm = 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (!hold_done && results_seen >= 60 && pixel_words.size() > 30)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            out_stall <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            if ($urandom_range(0, 63) == 0) drain_calm = !drain_calm;
            if (!drain_calm && $urandom_range(0, 4) == 0)
            begin
                stall_left = pick_pause() - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        pem_out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_edges.size() == 0)
            begin
                $error("unexpected result word: magnitude %0d frame_last %0d",
                       out_data.magnitude, out_data.frame_last);
                errors++;
            end
            else
            begin
                want = expected_edges.pop_front();
                results_seen++;
                if (out_data.magnitude !== want.magnitude)
                begin
                    $error("magnitude: expected %0d, got %0d", want.magnitude, out_data.magnitude);
                    errors++;
                end
                if (out_data.frame_last !== want.frame_last)
                begin
                    $error("frame_last: expected %0d, got %0d",
                           want.frame_last, out_data.frame_last);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $error("timeout with %0d words unsent and %0d results outstanding",
                   pixel_words.size(), expected_edges.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic drain_pipeline();
        while (pixel_words.size() != 0 || in_valid || expected_edges.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic index, input logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {index, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic apply_setting(input logic [8:0] width, input logic [12:0] height);
        drain_pipeline();
        write_reg(REG_LINE_WIDTH, 32'(width));
        write_reg(REG_FRAME_HEIGHT, 32'(height));
        cfg_width = width;
        cfg_height = height;
        settings_used++;
    endtask

    task automatic push_word(input logic [7:0] pix, input logic start);
        pem_in_t word;
        word.pixel = pix;
        word.frame_start = start;
        pixel_words.push_back(word);
    endtask

    task automatic queue_raster(input int count, input int restart_odds);
        int w;
        int h;
        int col;
        int row;
        logic start;
        w = eff_width();
        h = eff_height();
        col = 0;
        row = 0;
        for (int i = 0; i < count; i++)
        begin
            if (i == 0) start = 1'b1;
            else if (col == 0 && row == 0) start = ($urandom_range(0, 3) != 0);
            else start = (restart_odds != 0 && $urandom_range(1, restart_odds) == 1);
            if (start)
            begin
                col = 0;
                row = 0;
            end
            push_word(random_pixel(), start);
            if (col >= w - 1)
            begin
                col = 0;
                row = (row >= h - 1) ? 0 : row + 1;
            end
            else
            begin
                col++;
            end
        end
    endtask

    initial
    begin
        cfg_width = 9'd200;
        cfg_height = 13'd200;
        col_pos = 0;
        row_pos = 0;
        foreach (upper_line[i]) upper_line[i] = '0;
        foreach (middle_line[i]) middle_line[i] = '0;
        foreach (window_cols[i]) window_cols[i] = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        apply_setting(9'd3, 13'd3);
        for (int i = 0; i < 9; i++) push_word(8'd0, i == 0);
        for (int i = 0; i < 9; i++) push_word((i % 3 == 2) ? 8'd255 : 8'd0, i == 0);
        for (int i = 0; i < 9; i++) push_word(8'((i / 3) * 40), 1'b0);

        apply_setting(9'd0, 13'd0);
        queue_raster(18, 12);
        apply_setting(9'd4, 13'd5);
        queue_raster(20, 20);
        apply_setting(9'd511, 13'd3);
        queue_raster(770, 0);
        apply_setting(9'd6, 13'd8191);
        queue_raster(20, 25);
        apply_setting(9'd13, 13'd4);
        queue_raster(25, 30);
        apply_setting(9'd3, 13'd7);
        queue_raster(15, 10);
        drain_pipeline();

        $display("Sent %0d pixel words under %0d line and frame sizes; checked %0d edge results.",
                 words_accepted, settings_used, results_seen);
        $display("The run included one long output hold-off of %0d cycles.", HOLD_CYCLES);
        if (errors == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/pem_pkg.sv
hw/rtl/pem_line_store.sv
hw/rtl/pem_gradient.sv
hw/rtl/pem_root.sv
hw/rtl/prewitt_edge_magnitude.sv
tb/tb.sv
